### hdl/lptp_pkg.sv
package lptp_pkg;

  // link framing bytes
  localparam logic [7:0] PKT_HEAD  = 8'hA5;
  localparam logic [7:0] PKT_TYPE  = 8'h05;
  localparam logic [7:0] CMD_LEN   = 8'h03;
  localparam logic [7:0] CHAN_CMD  = 8'h00;
  localparam logic [7:0] CHAN_DATA = 8'h01;
  localparam logic [7:0] CMD_PAGE  = 8'hB0;
  localparam logic [7:0] CMD_COLHI = 8'h10;
  localparam logic [7:0] INV_MASK  = 8'hFF;

  // first panel column of group 0
  localparam int COL_BASE = 4;

  // byte positions inside a packet
  localparam int HDR_HEAD  = 0;
  localparam int HDR_TYPE  = 1;
  localparam int HDR_LEN   = 2;
  localparam int HDR_CHAN  = 3;
  localparam int HDR_BYTES = 4;

  // configuration register indexes
  localparam logic [1:0] REG_GROUPS = 2'd0;
  localparam logic [1:0] REG_PAGES  = 2'd1;
  localparam logic [1:0] REG_INVERT = 2'd2;

  localparam logic [2:0] GROUPS_RST = 3'd4;
  localparam logic [4:0] PAGES_RST  = 5'd8;
  localparam logic [2:0] GROUPS_MAX = 3'd4;
  localparam logic [4:0] PAGES_MAX  = 5'd16;

  typedef enum logic [1:0] {
    SEG_PAGE,
    SEG_COLHI,
    SEG_COLLO,
    SEG_DATA
  } seg_t;

  typedef struct packed {
    logic take;   // input request accepted this cycle
    logic load;   // load next link byte into the output register
    seg_t seg;    // packet being sent
  } lptp_cmd_t;

  typedef struct packed {
    logic group_end;    // offered byte closes a group
    logic first_group;  // offered byte belongs to group 0 of its page
  } lptp_sts_t;

endpackage

### hdl/lptp_ctrl.sv
module lptp_ctrl
  import lptp_pkg::*;
#(
  parameter int BYTES_PER_GROUP = 4,
  parameter int POS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic             out_tlast,
  input  lptp_sts_t        sts,
  output lptp_cmd_t        cmd,
  output logic [POS_W-1:0] pos
);

  localparam int GROUP_COLS = 8 * BYTES_PER_GROUP;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  seg_t             seg_r, seg_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic             take, adv, is_last, cmd_end;

  assign in_tready = (state_r == ST_IDLE);
  assign take      = in_tready && in_tvalid;
  assign adv       = !out_valid_r || out_tready;
  assign is_last   = (seg_r == SEG_DATA) && (pos_r == POS_W'(GROUP_COLS + HDR_BYTES - 1));
  assign cmd_end   = (seg_r != SEG_DATA) && (pos_r == POS_W'(HDR_BYTES));

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    cmd.take      = 1'b0;
    cmd.load      = 1'b0;
    cmd.seg       = seg_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.take = 1'b1;
          if (sts.group_end) begin
            state_nxt = ST_EMIT;
            seg_nxt   = sts.first_group ? SEG_PAGE : SEG_COLHI;
            pos_nxt   = '0;
          end
        end
      end
      ST_EMIT: begin
        if (adv) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_last_nxt  = is_last;
          if (cmd_end) begin
            seg_nxt = seg_t'(seg_r + 2'd1);
            pos_nxt = '0;
          end else if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seg_r       <= SEG_PAGE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign pos        = pos_r;

endmodule

### hdl/lptp_datapath.sv
module lptp_datapath
  import lptp_pkg::*;
#(
  parameter int BYTES_PER_GROUP = 4,
  parameter int POS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [4:0]       cfg_wdata,
  input  logic [7:0]       pixel_byte,
  input  logic             frame_start,
  input  lptp_cmd_t        cmd,
  input  logic [POS_W-1:0] pos,
  output lptp_sts_t        sts,
  output logic [7:0]       link_byte
);

  localparam int GROUP_COLS = 8 * BYTES_PER_GROUP;
  localparam int SUB_W      = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;

  logic [2:0]       groups_r;
  logic [4:0]       pages_r;
  logic             invert_r;

  logic [7:0]       row_store_r [8][BYTES_PER_GROUP];
  logic [2:0]       row_r, row_nxt, row_e;
  logic [SUB_W-1:0] sub_r, sub_nxt, sub_e;
  logic [1:0]       grp_r, grp_nxt, grp_e;
  logic [3:0]       page_r, page_nxt, page_e;
  logic [3:0]       emit_page_r;
  logic [7:0]       emit_col_r;
  logic [7:0]       out_byte_r, out_byte_nxt;

  logic [2:0]       gpp_c, grp_inc;
  logic [4:0]       pc_c, page_inc;
  logic             sub_last;
  logic [POS_W-1:0] colx;
  logic [SUB_W-1:0] sub_sel;
  logic [2:0]       bit_sel;
  logic [7:0]       col_byte, cmd_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_r <= GROUPS_RST;
      pages_r  <= PAGES_RST;
      invert_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GROUPS: groups_r <= cfg_wdata[2:0];
        REG_PAGES:  pages_r  <= cfg_wdata;
        REG_INVERT: invert_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  assign gpp_c = (groups_r == 3'd0) ? 3'd1 : (groups_r > GROUPS_MAX) ? GROUPS_MAX : groups_r;
  assign pc_c  = (pages_r == 5'd0) ? 5'd1 : (pages_r > PAGES_MAX) ? PAGES_MAX : pages_r;

  // frame start clears the counters ahead of this byte
  assign row_e  = frame_start ? 3'd0 : row_r;
  assign sub_e  = frame_start ? '0 : sub_r;
  assign grp_e  = frame_start ? 2'd0 : grp_r;
  assign page_e = frame_start ? 4'd0 : page_r;

  assign sub_last        = (sub_e == SUB_W'(BYTES_PER_GROUP - 1));
  assign sts.group_end   = (row_e == 3'd7) && sub_last;
  assign sts.first_group = (grp_e == 2'd0);

  assign grp_inc  = {1'b0, grp_e} + 3'd1;
  assign page_inc = {1'b0, page_e} + 5'd1;

  always_comb begin
    row_nxt  = row_r;
    sub_nxt  = sub_r;
    grp_nxt  = grp_r;
    page_nxt = page_r;
    if (cmd.take) begin
      grp_nxt  = grp_e;
      page_nxt = page_e;
      if (sts.group_end) begin
        row_nxt = 3'd0;
        sub_nxt = '0;
        if (grp_inc >= gpp_c) begin
          grp_nxt  = 2'd0;
          page_nxt = (page_inc >= pc_c) ? 4'd0 : page_inc[3:0];
        end else begin
          grp_nxt = grp_inc[1:0];
        end
      end else if (sub_last) begin
        row_nxt = row_e + 3'd1;
        sub_nxt = '0;
      end else begin
        row_nxt = row_e;
        sub_nxt = sub_e + SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= 3'd0;
      sub_r  <= '0;
      grp_r  <= 2'd0;
      page_r <= 4'd0;
    end else begin
      row_r  <= row_nxt;
      sub_r  <= sub_nxt;
      grp_r  <= grp_nxt;
      page_r <= page_nxt;
    end
  end

  // rows are stored as they arrive; columns are picked out on the way out
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_store_r[row_e][sub_e] <= invert_r ? (pixel_byte ^ INV_MASK) : pixel_byte;
      if (sts.group_end) begin
        emit_page_r <= page_e;
        emit_col_r  <= 8'(COL_BASE) + 8'(GROUP_COLS) * {6'd0, grp_e};
      end
    end
  end

  always_comb begin
    colx    = pos - POS_W'(HDR_BYTES);
    sub_sel = SUB_W'(colx >> 3);
    bit_sel = colx[2:0];
    for (int k = 0; k < 8; k++) begin
      col_byte[k] = row_store_r[k][sub_sel][3'd7 - bit_sel];
    end
  end

  always_comb begin
    case (cmd.seg)
      SEG_PAGE:  cmd_byte = CMD_PAGE | {4'd0, emit_page_r};
      SEG_COLHI: cmd_byte = CMD_COLHI + {4'd0, emit_col_r[7:4]};
      SEG_COLLO: cmd_byte = {4'd0, emit_col_r[3:0]};
      default:   cmd_byte = CHAN_CMD;
    endcase
  end

  always_comb begin
    case (pos)
      POS_W'(HDR_HEAD): out_byte_nxt = PKT_HEAD;
      POS_W'(HDR_TYPE): out_byte_nxt = PKT_TYPE;
      POS_W'(HDR_LEN):  out_byte_nxt = (cmd.seg == SEG_DATA) ? 8'(GROUP_COLS + 2) : CMD_LEN;
      POS_W'(HDR_CHAN): out_byte_nxt = (cmd.seg == SEG_DATA) ? CHAN_DATA : CHAN_CMD;
      default:          out_byte_nxt = (cmd.seg == SEG_DATA) ? col_byte : cmd_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= out_byte_nxt;
    end
  end

  assign link_byte = out_byte_r;

endmodule

### hdl/lcd_page_transpose_packetizer.sv
// Panel page packetizer.
// Input stream: one horizontal-bitmap byte per request, MSB = leftmost pixel,
// in_tuser flags the first byte of a frame. Bytes come row by row within a
// group of BYTES_PER_GROUP bytes x 8 rows, groups left to right, pages top down.
// Output stream: framed link bytes, out_tlast on the final byte of the packets
// caused by one input byte. Only the byte that closes a group produces output:
// an optional page-select command, column-high and column-low commands and one
// data packet of 8*BYTES_PER_GROUP vertical column bytes.
// Config port: cfg_wr_en/cfg_index/cfg_wdata, write only while idle.
// Timing: the closing input byte moves the sequencer state register to sending;
// the output register then loads the first link byte and the packets leave at
// one byte per cycle while the receiver is ready (51 bytes at the default size,
// 46 when no page command); no input is taken until the last of them is in the
// output register. The single output register and byte sequencer set the rate.
// Reset clears counters, configuration and the output valid flag; the row store
// needs no clearing. A stalled receiver holds the current link byte and the
// sequencer waits with it.
module lcd_page_transpose_packetizer
  import lptp_pkg::*;
#(
  parameter int BYTES_PER_GROUP = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] pixel_byte
  input  logic       in_tuser,   // [0] frame_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] link_byte
  output logic       out_tlast   // last_of_run
);

  localparam int POS_W = $clog2(8 * BYTES_PER_GROUP + HDR_BYTES);

  lptp_cmd_t        cmd;
  lptp_sts_t        sts;
  logic [POS_W-1:0] pos;

  lptp_ctrl #(
    .BYTES_PER_GROUP(BYTES_PER_GROUP),
    .POS_W(POS_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tlast (out_tlast),
    .sts       (sts),
    .cmd       (cmd),
    .pos       (pos)
  );

  lptp_datapath #(
    .BYTES_PER_GROUP(BYTES_PER_GROUP),
    .POS_W(POS_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pixel_byte (in_tdata),
    .frame_start(in_tuser),
    .cmd        (cmd),
    .pos        (pos),
    .sts        (sts),
    .link_byte  (out_tdata)
  );

endmodule

### hdl/lptp_checker.sv
module lptp_checker
  import lptp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled link byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("link byte changed under stall");

  // no input request taken while a run is still being sent
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a run");

  // a run is followed by a gap before the next one starts
  a_gap_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("link byte right after end of run");

  // every run opens with a packet head
  a_run_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata == PKT_HEAD)
    else $error("run does not start with packet head");

endmodule

bind lcd_page_transpose_packetizer lptp_checker u_lptp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lptp_pkg::*;

  localparam int BPG         = 4;
  localparam int GROUP_COLS  = 8 * BPG;
  localparam int GROUP_BYTES = 8 * BPG;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 60;

  typedef enum logic [0:0] {
    PAT_CONST,
    PAT_RAND
  } pat_t;

  // one directed row: an optional register update, then a run of pixel bytes
  typedef struct packed {
    logic       wr_cfg;
    logic [2:0] groups;
    logic [4:0] pages;
    logic       invert;
    pat_t       pat;
    logic [7:0] value;
    logic [5:0] count;
    logic       fs;
    logic       chk;
    logic [7:0] fill;
  } dir_row_t;

  typedef struct {
    logic [7:0] px;
    logic       fs;
    logic       chk;
    logic [7:0] fill;
  } pixel_req_t;

  typedef struct {
    logic [7:0] link;
    logic       last;
  } link_beat_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       cfg_wr_en  = 1'b0;
  logic [1:0] cfg_index  = REG_GROUPS;
  logic [4:0] cfg_wdata  = '0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b1;
  logic [7:0] out_tdata;
  logic       out_tlast;

  lcd_page_transpose_packetizer #(
    .BYTES_PER_GROUP(BPG)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  pixel_req_t px_pending[$];
  link_beat_t link_expect[$];

  logic steady   = 1'b0;
  logic hold_req = 1'b0;

  int unsigned mismatches    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned groups_closed = 0;

  // transpose and packet state
  logic [7:0] col_store [GROUP_COLS];
  logic [4:0] byte_pos   = '0;
  logic [1:0] group_idx  = '0;
  logic [3:0] page_idx   = '0;
  logic [2:0] cfg_groups = GROUPS_RST;
  logic [4:0] cfg_pages  = PAGES_RST;
  logic       cfg_invert = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_link(input logic [7:0] b, input logic last);
    link_beat_t beat;
    beat.link = b;
    beat.last = last;
    link_expect.push_back(beat);
  endtask

  task automatic push_cmd(input logic [7:0] cmd);
    push_link(PKT_HEAD, 1'b0);
    push_link(PKT_TYPE, 1'b0);
    push_link(CMD_LEN, 1'b0);
    push_link(CHAN_CMD, 1'b0);
    push_link(cmd, 1'b0);
  endtask

  // store one accepted pixel byte and queue the packets of a closed group
  task automatic absorb_pixel(input pixel_req_t req);
    logic [7:0] px;
    int unsigned row, sub, gpp, pc, col;
    if (req.fs) begin
      byte_pos  = '0;
      group_idx = '0;
      page_idx  = '0;
    end
    px = cfg_invert ? (req.px ^ INV_MASK) : req.px;
    row = byte_pos / BPG;
    sub = byte_pos % BPG;
    for (int i = 0; i < 8; i++) begin
      col_store[(sub * 8 + i) % GROUP_COLS][row % 8] = px[7 - i];
    end
    if (byte_pos != 5'(GROUP_BYTES - 1)) begin
      byte_pos++;
      return;
    end
    gpp = (cfg_groups == 0) ? 1 : (cfg_groups > GROUPS_MAX) ? GROUPS_MAX : cfg_groups;
    pc  = (cfg_pages == 0) ? 1 : (cfg_pages > PAGES_MAX) ? PAGES_MAX : cfg_pages;
    if (group_idx == 0) begin
      push_cmd(CMD_PAGE + 8'(page_idx));
    end
    col = COL_BASE + GROUP_COLS * group_idx;
    push_cmd(CMD_COLHI + 8'((col >> 4) & 15));
    push_cmd(8'(col & 15));
    push_link(PKT_HEAD, 1'b0);
    push_link(PKT_TYPE, 1'b0);
    push_link(8'(GROUP_COLS + 2), 1'b0);
    push_link(CHAN_DATA, 1'b0);
    for (int i = 0; i < GROUP_COLS; i++) begin
      push_link(req.chk ? req.fill : col_store[i], i == GROUP_COLS - 1);
    end
    groups_closed++;
    byte_pos = '0;
    if (group_idx + 1 >= gpp) begin
      group_idx = '0;
      page_idx  = (page_idx + 1 >= pc) ? 4'd0 : page_idx + 4'd1;
    end else begin
      group_idx++;
    end
  endtask

  task automatic check_link(input logic [7:0] b, input logic last);
    link_beat_t beat;
    if (link_expect.size() == 0) begin
      report_mismatch($sformatf("link byte %02h with nothing pending", b));
    end else begin
      beat = link_expect.pop_front();
      beats_checked++;
      if (b !== beat.link) begin
        report_mismatch($sformatf("link byte %02h, want %02h", b, beat.link));
      end
      if (last !== beat.last) begin
        report_mismatch($sformatf("last flag %b, want %b", last, beat.last));
      end
    end
  endtask

  initial begin : pixel_driver
    pixel_req_t cur;
    int unsigned gap;
    gap = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        absorb_pixel(cur);
        bytes_sent++;
      end
      // hold a request that has not been taken yet
      if (!in_tvalid || in_tready) begin
        if (gap != 0) begin
          gap--;
          in_tvalid <= 1'b0;
        end else if (px_pending.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
          gap = $urandom_range(0, 9);
          in_tvalid <= 1'b0;
        end else begin
          cur = px_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur.px;
          in_tuser  <= cur.fs;
        end
      end
    end
  end

  initial begin : link_sink
    int unsigned stall, hold;
    stall = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_link(out_tdata, out_tlast);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = LONG_HOLD;
      end
      if (hold != 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_bytes(input pat_t pat, input logic [7:0] value, input int unsigned len,
                             input logic fs, input logic chk, input logic [7:0] fill);
    pixel_req_t req;
    for (int k = 0; k < len; k++) begin
      req.px   = (pat == PAT_CONST) ? value : pick_pixel();
      req.fs   = fs && (k == 0);
      req.chk  = chk;
      req.fill = fill;
      px_pending.push_back(req);
    end
  endtask

  // block is idle once every request is taken and every link byte has come
  task automatic wait_idle();
    do @(negedge clk);
    while (px_pending.size() != 0 || in_tvalid || link_expect.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input logic [2:0] groups, input logic [4:0] pages,
                            input logic invert);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_GROUPS;
    cfg_wdata <= 5'(groups);
    @(posedge clk);
    cfg_index <= REG_PAGES;
    cfg_wdata <= pages;
    @(posedge clk);
    cfg_index <= REG_INVERT;
    cfg_wdata <= 5'(invert);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_groups = groups;
    cfg_pages  = pages;
    cfg_invert = invert;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [2:0] groups, input logic [4:0] pages,
                           input logic invert, input int unsigned n_groups, input logic noisy);
    wait_idle();
    set_config(groups, pages, invert);
    for (int g = 0; g < n_groups; g++) begin
      // broken sequences: a short run, sometimes cut off by a new frame
      if (noisy && $urandom_range(0, 4) == 0) begin
        queue_bytes(PAT_RAND, 8'h00, $urandom_range(1, GROUP_BYTES - 1),
                    1'($urandom_range(0, 1)), 1'b0, 8'h00);
      end
      queue_bytes(PAT_RAND, 8'h00, GROUP_BYTES,
                  (g == 0) || (noisy && $urandom_range(0, 5) == 0), 1'b0, 8'h00);
    end
  endtask

  dir_row_t dir_rows [8];

  initial begin : main
    dir_row_t r;
    // after reset, defaults: page 0 groups 0 to 2
    dir_rows[0] = '{1'b0, 3'd0, 5'd0,  1'b0, PAT_CONST, 8'h00, 6'd32, 1'b1, 1'b1, 8'h00};
    dir_rows[1] = '{1'b0, 3'd0, 5'd0,  1'b0, PAT_CONST, 8'hFF, 6'd32, 1'b0, 1'b1, 8'hFF};
    dir_rows[2] = '{1'b0, 3'd0, 5'd0,  1'b0, PAT_CONST, 8'h80, 6'd32, 1'b0, 1'b0, 8'h00};
    // one group per page, one page: wrap on every group, inverted pixels
    dir_rows[3] = '{1'b1, 3'd1, 5'd1,  1'b1, PAT_CONST, 8'h00, 6'd32, 1'b1, 1'b1, 8'hFF};
    dir_rows[4] = '{1'b0, 3'd0, 5'd0,  1'b0, PAT_CONST, 8'hFF, 6'd32, 1'b0, 1'b1, 8'h00};
    // zero counts act as one
    dir_rows[5] = '{1'b1, 3'd0, 5'd0,  1'b0, PAT_RAND,  8'h00, 6'd32, 1'b0, 1'b0, 8'h00};
    // partial group, then a frame start in the middle of it
    dir_rows[6] = '{1'b0, 3'd0, 5'd0,  1'b0, PAT_RAND,  8'h00, 6'd13, 1'b0, 1'b0, 8'h00};
    // oversized counts clamp to the top
    dir_rows[7] = '{1'b1, 3'd7, 5'd31, 1'b0, PAT_RAND,  8'h00, 6'd32, 1'b1, 1'b0, 8'h00};

    for (int i = 0; i < GROUP_COLS; i++) col_store[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.wr_cfg) begin
        wait_idle();
        set_config(r.groups, r.pages, r.invert);
      end
      queue_bytes(r.pat, r.value, r.count, r.fs, r.chk, r.fill);
    end

    // long output hold while requests keep coming
    wait_idle();
    hold_req = 1'b1;
    run_phase(3'd1, 5'd16, 1'($urandom_range(0, 1)), 2, 1'b0);
    run_phase(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
              1, 1'b1);
    wait_idle();
    steady = 1'b1;
    run_phase(GROUPS_MAX, 5'($urandom_range(1, 16)), 1'($urandom_range(0, 1)), 1, 1'b0);

    do @(negedge clk);
    while (px_pending.size() != 0 || in_tvalid || link_expect.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d pixel bytes in %0d closed groups, %0d link bytes checked",
             bytes_sent, groups_closed, beats_checked);
    $display("Swept group and page counts from zero to above range, both pixel polarities");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### lcd_page_transpose_packetizer.f
hdl/lptp_pkg.sv
hdl/lptp_ctrl.sv
hdl/lptp_datapath.sv
hdl/lcd_page_transpose_packetizer.sv
hdl/lptp_checker.sv
bench/tb.sv
